[rtl/wrrb_pkg.sv]
// Shared types and constants for the weighted ring replay buffer.
// No dependencies; used by wrrb_ctrl, wrrb_dpath and the top level.
package wrrb_pkg;

	localparam int CAPACITY_DEF = 1024;

	localparam int FUNC_W   = 3;
	localparam int WEIGHT_W = 32;
	localparam int CNT_W    = 11;
	localparam int ID_W     = 10;
	localparam int STS_W    = 2;
	localparam int OCC_W    = 11;
	localparam int SUM_W    = 48;

	// shift of the fixed-point reciprocal used for index mod CAPACITY
	localparam int RCP_SH = 20;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 3'd0,
		FN_POP    = 3'd1,
		FN_UPDATE = 3'd2,
		FN_READ   = 3'd3,
		FN_MARK   = 3'd4,
		FN_CLEAR  = 3'd5
	} func_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_POP_OVER = 2'd2,
		STS_EVICTED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_ADDR,
		S_PCHK,
		S_POP,
		S_CLR,
		S_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic clr_start;
		logic clr_step;
		logic rd_issue;
		logic pop_check;
		logic pop_step;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pop_over;
		logic rem_zero;
		logic pop_pend;
		logic clr_last;
	} sts_t;

endpackage

[rtl/wrrb_ctrl.sv]
// Sequencer for the weighted ring replay buffer: state machine and result valid.
// Depends on wrrb_pkg (state, command and status types, function codes).
module wrrb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wrrb_pkg::FUNC_W-1:0] func,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  wrrb_pkg::sts_t              sts,
	output wrrb_pkg::cmd_t              cmd
);

	wrrb_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrrb_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			wrrb_pkg::S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = wrrb_pkg::S_IDLE;
				end
			end
			wrrb_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					unique case (func) inside
						wrrb_pkg::FN_POP: begin
							state_d = wrrb_pkg::S_PCHK;
						end
						wrrb_pkg::FN_UPDATE, wrrb_pkg::FN_READ, wrrb_pkg::FN_MARK: begin
							state_d = wrrb_pkg::S_ADDR;
						end
						wrrb_pkg::FN_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = wrrb_pkg::S_CLR;
						end
						default: begin
							state_d = wrrb_pkg::S_FIN;
						end
					endcase
				end
			end
			wrrb_pkg::S_ADDR: begin
				cmd.rd_issue = 1'b1;
				state_d      = wrrb_pkg::S_FIN;
			end
			wrrb_pkg::S_PCHK: begin
				cmd.pop_check = 1'b1;
				state_d       = sts.pop_over ? wrrb_pkg::S_FIN : wrrb_pkg::S_POP;
			end
			wrrb_pkg::S_POP: begin
				if (!sts.rem_zero) begin
					cmd.pop_step = 1'b1;
				end else if (!sts.pop_pend) begin
					state_d = wrrb_pkg::S_FIN;
				end
			end
			wrrb_pkg::S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = wrrb_pkg::S_FIN;
				end
			end
			wrrb_pkg::S_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = wrrb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = wrrb_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a result never overwrites one that is still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result loaded over a waiting result");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_step |-> !sts.rem_zero)
		else $error("pop step with nothing left to pop");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (sts.rem_zero && !sts.pop_pend))
		else $error("ready while a pop walk is in flight");

endmodule

[rtl/wrrb_dpath.sv]
// Datapath of the weighted ring replay buffer: weight and eviction memories,
// ring pointers, fill count, weight sum, index reduction and result register.
// Depends on wrrb_pkg (widths, codes, command and status types).
module wrrb_dpath #(
	parameter int CAPACITY = wrrb_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [wrrb_pkg::FUNC_W-1:0]   func,
	input  logic [wrrb_pkg::WEIGHT_W-1:0] weight_in,
	input  logic [wrrb_pkg::CNT_W-1:0]    pop_count,
	input  logic [wrrb_pkg::ID_W-1:0]     slot_id,
	input  logic [wrrb_pkg::ID_W-1:0]     logical_index,
	input  wrrb_pkg::cmd_t                cmd,
	output wrrb_pkg::sts_t                sts,
	output logic [wrrb_pkg::STS_W-1:0]    status,
	output logic [wrrb_pkg::ID_W-1:0]     slot,
	output logic [wrrb_pkg::WEIGHT_W-1:0] weight_out,
	output logic [wrrb_pkg::OCC_W-1:0]    occupancy,
	output logic [wrrb_pkg::SUM_W-1:0]    total_weight
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = wrrb_pkg::ID_W;
	localparam int WW   = wrrb_pkg::WEIGHT_W;
	localparam int SW   = wrrb_pkg::SUM_W;
	localparam int RSH  = wrrb_pkg::RCP_SH;
	localparam int CMPW = (CW > wrrb_pkg::CNT_W) ? CW : wrrb_pkg::CNT_W;
	localparam int RW   = (CW > IW) ? CW : IW;
	localparam int PW   = IW + CW;
	localparam int P1W  = IW + RSH;

	localparam logic [AW-1:0]  LAST     = AW'(CAPACITY - 1);
	localparam logic [CW-1:0]  FULL_CNT = CW'(CAPACITY);
	localparam logic [RSH-1:0] RCP      = RSH'((1 << RSH) / CAPACITY);

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		ring_inc = (p == LAST) ? '0 : p + AW'(1);
	endfunction

	// captured item
	logic [wrrb_pkg::FUNC_W-1:0] func_q;
	logic [WW-1:0]               w_q;
	logic [wrrb_pkg::CNT_W-1:0]  cnt_q;
	logic [IW-1:0]               idx_q;
	logic [IW-1:0]               q0_q;

	// ring state
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [SW-1:0] sum_q, sum_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [CW-1:0] rem_q, rem_d;
	logic          pend_q;
	logic          pop_err_q;

	// memory side
	logic [WW-1:0] wmem [CAPACITY];
	logic          emem [CAPACITY];
	logic [AW-1:0] slot_q;
	logic [WW-1:0] rd_w_q;
	logic          rd_e_q;
	logic          w_we, w_re, e_we, e_wd;
	logic [AW-1:0] w_wa, w_ra, e_wa;
	logic [WW-1:0] w_wd;

	// result register
	wrrb_pkg::status_t         res_status_q;
	logic [IW-1:0]             res_slot_q;
	logic [WW-1:0]             res_wout_q;
	logic [wrrb_pkg::OCC_W-1:0] res_occ_q;
	logic [SW-1:0]             res_sum_q;

	logic                      full;
	logic                      pop_over;
	logic [IW-1:0]             idx_sel;
	logic [P1W-1:0]            prod1;
	logic [PW-1:0]             prod2;
	logic [PW-1:0]             r0;
	logic [RW-1:0]             r0_n, r_red;
	logic [AW-1:0]             r_aw;
	logic [AW:0]               s_sum, s_wrap;
	logic [AW-1:0]             addr_c;

	wrrb_pkg::status_t         fin_status;
	logic [IW-1:0]             fin_slot;
	logic [WW-1:0]             fin_wout;

	assign full     = (fill_q == FULL_CNT);
	assign pop_over = (CMPW'(cnt_q) > CMPW'(fill_q));

	// index mod CAPACITY: reciprocal estimate now, one correction after the register
	assign idx_sel = (func == wrrb_pkg::FN_UPDATE) ? slot_id : logical_index;
	assign prod1   = P1W'(idx_sel) * P1W'(RCP);

	assign prod2 = PW'(q0_q) * PW'(CAPACITY);
	assign r0    = PW'(idx_q) - prod2;
	assign r0_n  = RW'(r0[IW-1:0]);
	assign r_red = (r0_n >= RW'(CAPACITY)) ? r0_n - RW'(CAPACITY) : r0_n;
	assign r_aw  = AW'(r_red);

	assign s_sum  = (AW+1)'(head_q) + (AW+1)'(r_aw);
	assign s_wrap = (s_sum >= (AW+1)'(CAPACITY)) ? s_sum - (AW+1)'(CAPACITY) : s_sum;
	assign addr_c = (func_q == wrrb_pkg::FN_UPDATE) ? r_aw : AW'(s_wrap);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			w_q    <= weight_in;
			cnt_q  <= pop_count;
			idx_q  <= idx_sel;
			q0_q   <= prod1[P1W-1:RSH];
		end
	end

	// next values of the ring state
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		fill_d = fill_q;
		sum_d  = sum_q;
		clr_d  = clr_q;
		rem_d  = rem_q;
		if (cmd.clr_start) begin
			head_d = '0;
			tail_d = '0;
			fill_d = '0;
			sum_d  = '0;
			clr_d  = '0;
		end
		if (cmd.clr_step) begin
			clr_d = ring_inc(clr_q);
		end
		if (cmd.pop_check && !pop_over) begin
			fill_d = fill_q - CW'(cnt_q);
			rem_d  = CW'(cnt_q);
		end
		if (cmd.pop_step) begin
			head_d = ring_inc(head_q);
			rem_d  = rem_q - CW'(1);
		end
		if (pend_q) begin
			sum_d = sum_q - SW'(rd_w_q);
		end
		if (cmd.finish) begin
			if (func_q == wrrb_pkg::FN_APPEND && !full) begin
				tail_d = ring_inc(tail_q);
				fill_d = fill_q + CW'(1);
				sum_d  = sum_q + SW'(w_q);
			end else if (func_q == wrrb_pkg::FN_UPDATE && !rd_e_q) begin
				sum_d = sum_q + SW'(w_q) - SW'(rd_w_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
			clr_q     <= '0;
			rem_q     <= '0;
			pend_q    <= 1'b0;
			pop_err_q <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_d;
			sum_q  <= sum_d;
			clr_q  <= clr_d;
			rem_q  <= rem_d;
			pend_q <= cmd.pop_step;
			if (cmd.pop_check) begin
				pop_err_q <= pop_over;
			end
		end
	end

	// memory ports
	always_comb begin
		w_we = 1'b0;
		w_wa = clr_q;
		w_wd = '0;
		if (cmd.clr_step) begin
			w_we = 1'b1;
		end else if (cmd.finish && func_q == wrrb_pkg::FN_APPEND && !full) begin
			w_we = 1'b1;
			w_wa = tail_q;
			w_wd = w_q;
		end else if (cmd.finish && func_q == wrrb_pkg::FN_UPDATE && !rd_e_q) begin
			w_we = 1'b1;
			w_wa = slot_q;
			w_wd = w_q;
		end

		e_we = 1'b0;
		e_wa = clr_q;
		e_wd = 1'b0;
		if (cmd.clr_step) begin
			e_we = 1'b1;
		end else if (cmd.pop_step) begin
			e_we = 1'b1;
			e_wa = head_q;
			e_wd = 1'b1;
		end else if (cmd.finish && func_q == wrrb_pkg::FN_MARK) begin
			e_we = 1'b1;
			e_wa = slot_q;
		end

		w_re = cmd.pop_step || cmd.rd_issue;
		w_ra = cmd.pop_step ? head_q : addr_c;
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_wa] <= w_wd;
		end
		if (w_re) begin
			rd_w_q <= wmem[w_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			emem[e_wa] <= e_wd;
		end
		if (cmd.rd_issue) begin
			rd_e_q <= emem[addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			slot_q <= addr_c;
		end
	end

	// result fields
	always_comb begin
		fin_status = wrrb_pkg::STS_OK;
		fin_slot   = IW'(head_q);
		fin_wout   = '0;
		case (func_q) inside
			wrrb_pkg::FN_APPEND: begin
				fin_slot = IW'(tail_q);
				if (full) begin
					fin_status = wrrb_pkg::STS_FULL;
				end else begin
					fin_wout = w_q;
				end
			end
			wrrb_pkg::FN_POP: begin
				if (pop_err_q) begin
					fin_status = wrrb_pkg::STS_POP_OVER;
				end
			end
			wrrb_pkg::FN_UPDATE: begin
				fin_slot = IW'(slot_q);
				if (rd_e_q) begin
					fin_status = wrrb_pkg::STS_EVICTED;
					fin_wout   = rd_w_q;
				end else begin
					fin_wout = w_q;
				end
			end
			wrrb_pkg::FN_READ, wrrb_pkg::FN_MARK: begin
				fin_slot = IW'(slot_q);
				fin_wout = rd_w_q;
			end
			default: begin
				fin_status = wrrb_pkg::STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_status_q <= fin_status;
			res_slot_q   <= fin_slot;
			res_wout_q   <= fin_wout;
			res_occ_q    <= wrrb_pkg::OCC_W'(fill_d);
			res_sum_q    <= sum_d;
		end
	end

	assign status       = res_status_q;
	assign slot         = res_slot_q;
	assign weight_out   = res_wout_q;
	assign occupancy    = res_occ_q;
	assign total_weight = res_sum_q;

	assign sts.pop_over = pop_over;
	assign sts.rem_zero = (rem_q == '0);
	assign sts.pop_pend = pend_q;
	assign sts.clr_last = (clr_q == LAST);

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond capacity");

	// outside a pop walk, head meets tail only when empty or full
	a_ring_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == '0 && !pend_q) |->
		((head_q == tail_q) == (fill_q == '0 || fill_q == FULL_CNT)))
		else $error("ring pointers disagree with fill count");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> ((AW+1)'(addr_c) < (AW+1)'(CAPACITY)))
		else $error("reduced slot address out of range");

	a_pend_fin: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !cmd.finish)
		else $error("result taken before the last pop subtraction");

endmodule

[rtl/weighted_ring_replay_buffer_core.sv]
// Top level of the weighted ring replay buffer: sequencer plus datapath.
// Depends on wrrb_pkg, wrrb_ctrl and wrrb_dpath.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | func, weight_in, pop_count, slot_id,
//          |                     | logical_index
//  out     | out_valid/out_ready | status, slot, weight_out, occupancy,
//          |                     | total_weight
//
// Per item: append and unused codes go straight to write-back; update / read /
// mark-and-read do address reduction and memory read, then write-back; a pop of
// N entries checks N, then walks them one slot a cycle through the weight memory
// read port, then writes back (a rejected pop skips the walk); a clear sweeps one
// slot a cycle through the memories. After reset the block sweeps both memories
// to zero with in_ready low. A waiting result does not stop the next item being
// taken; only the final write-back stalls until the output register is free.
module weighted_ring_replay_buffer_core #(
	parameter int CAPACITY = wrrb_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item in
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wrrb_pkg::FUNC_W-1:0]   func,
	input  logic [wrrb_pkg::WEIGHT_W-1:0] weight_in,
	input  logic [wrrb_pkg::CNT_W-1:0]    pop_count,
	input  logic [wrrb_pkg::ID_W-1:0]     slot_id,
	input  logic [wrrb_pkg::ID_W-1:0]     logical_index,
	// item out
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wrrb_pkg::STS_W-1:0]    status,
	output logic [wrrb_pkg::ID_W-1:0]     slot,
	output logic [wrrb_pkg::WEIGHT_W-1:0] weight_out,
	output logic [wrrb_pkg::OCC_W-1:0]    occupancy,
	output logic [wrrb_pkg::SUM_W-1:0]    total_weight
);

	// commands down, status up: the only coupling between the two halves
	wrrb_pkg::cmd_t cmd;
	wrrb_pkg::sts_t sts;

	// sequencer: decodes func on acceptance, walks pops and clears,
	// holds the result valid
	wrrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: weight and evicted-mark memories, head/tail/fill/sum,
	// index mod CAPACITY and the result register
	wrrb_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.weight_in     (weight_in),
		.pop_count     (pop_count),
		.slot_id       (slot_id),
		.logical_index (logical_index),
		.cmd           (cmd),
		.sts           (sts),
		.status        (status),
		.slot          (slot),
		.weight_out    (weight_out),
		.occupancy     (occupancy),
		.total_weight  (total_weight)
	);

endmodule

[tb/weighted_ring_replay_buffer_core_tb.sv]
// Self-checking bench for weighted_ring_replay_buffer_core: a directed opening,
// then a weighted random mix with bursty traffic.
// Depends on wrrb_pkg and the RTL of the block; needs no other files.
module weighted_ring_replay_buffer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wrrb_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	localparam int RANDOM_OPS  = 880;
	localparam int DRAIN_EVERY = 150;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 60;

	// func codes the block treats as a no-op
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	typedef struct {
		logic [FUNC_W-1:0]   fn;
		logic [WEIGHT_W-1:0] w;
		logic [CNT_W-1:0]    cnt;
		logic [ID_W-1:0]     sid;
		logic [ID_W-1:0]     lidx;
	} request_t;

	typedef struct {
		status_t             sts;
		logic [ID_W-1:0]     slot;
		logic [WEIGHT_W-1:0] weight;
		logic [OCC_W-1:0]    occ;
		logic [SUM_W-1:0]    total;
	} reply_t;

	// Ring model plus the queue of replies still owed by the block.
	class replay_scoreboard;
		logic [WEIGHT_W-1:0] weights [CAP];
		bit                  evicted [CAP];
		int unsigned         head;
		int unsigned         tail;
		int unsigned         fill;
		logic [SUM_W-1:0]    sum;
		reply_t              owed [$];
		int                  errors;
		int                  checked;
		int                  op_seen [8];
		int                  sts_seen [4];

		function new();
			wipe();
			errors  = 0;
			checked = 0;
			foreach (op_seen[i])
				op_seen[i] = 0;
			foreach (sts_seen[i])
				sts_seen[i] = 0;
		endfunction

		function void wipe();
			foreach (weights[i]) begin
				weights[i] = '0;
				evicted[i] = 1'b0;
			end
			head = 0;
			tail = 0;
			fill = 0;
			sum  = '0;
		endfunction

		function void note_request(request_t r);
			reply_t      e;
			int unsigned s;
			e.sts    = STS_OK;
			e.weight = '0;
			s        = head;
			case (r.fn)
				FN_APPEND: begin
					s = tail;
					if (fill >= CAP) begin
						e.sts = STS_FULL;
					end else begin
						weights[s] = r.w;
						sum        = sum + r.w;
						tail       = (tail + 1) % CAP;
						fill++;
						e.weight   = r.w;
					end
				end
				FN_POP: begin
					if (r.cnt > fill) begin
						e.sts = STS_POP_OVER;
					end else begin
						for (int i = 0; i < r.cnt; i++) begin
							sum           = sum - weights[head];
							evicted[head] = 1'b1;
							head          = (head + 1) % CAP;
						end
						fill = fill - r.cnt;
					end
					s = head;
				end
				FN_UPDATE: begin
					s = r.sid % CAP;
					if (evicted[s]) begin
						e.sts    = STS_EVICTED;
						e.weight = weights[s];
					end else begin
						sum        = sum + r.w - weights[s];
						weights[s] = r.w;
						e.weight   = r.w;
					end
				end
				FN_READ: begin
					s        = (head + r.lidx) % CAP;
					e.weight = weights[s];
				end
				FN_MARK: begin
					s          = (head + r.lidx) % CAP;
					evicted[s] = 1'b0;
					e.weight   = weights[s];
				end
				FN_CLEAR: begin
					wipe();
					s = 0;
				end
				default: ;
			endcase
			e.slot  = s[ID_W-1:0];
			e.occ   = fill[OCC_W-1:0];
			e.total = sum;
			op_seen[r.fn]++;
			sts_seen[e.sts]++;
			owed.push_back(e);
		endfunction

		function void flag(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
		endfunction

		function void check_reply(logic [STS_W-1:0] sts, logic [ID_W-1:0] slot,
				logic [WEIGHT_W-1:0] weight, logic [OCC_W-1:0] occ,
				logic [SUM_W-1:0] total);
			reply_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: unexpected result, expected none, actual slot %0h",
						$time, slot);
				return;
			end
			e = owed.pop_front();
			checked++;
			if (sts !== e.sts)
				flag("status", e.sts, sts);
			if (slot !== e.slot)
				flag("slot", e.slot, slot);
			if (weight !== e.weight)
				flag("weight_out", e.weight, weight);
			if (occ !== e.occ)
				flag("occupancy", e.occ, occ);
			if (total !== e.total)
				flag("total_weight", e.total, total);
		endfunction
	endclass

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func          = '0;
	logic [WEIGHT_W-1:0] weight_in     = '0;
	logic [CNT_W-1:0]    pop_count     = '0;
	logic [ID_W-1:0]     slot_id       = '0;
	logic [ID_W-1:0]     logical_index = '0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	logic [STS_W-1:0]    status;
	logic [ID_W-1:0]     slot;
	logic [WEIGHT_W-1:0] weight_out;
	logic [OCC_W-1:0]    occupancy;
	logic [SUM_W-1:0]    total_weight;

	replay_scoreboard sb = new();

	int burst_left = 0;
	int cycles     = 0;
	int ready_run  = 0;
	int ready_mode = 0;

	weighted_ring_replay_buffer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.weight_in     (weight_in),
		.pop_count     (pop_count),
		.slot_id       (slot_id),
		.logical_index (logical_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot          (slot),
		.weight_out    (weight_out),
		.occupancy     (occupancy),
		.total_weight  (total_weight)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop: covers the post-reset memory sweep, every clear and the long pops
	// many times over.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycles, sb.owed.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver back-pressure: switches between always ready, coin toss, mostly
	// ready and a slow pattern that raises ready only while the run counter's low four
	// bits are above eleven.
	always @(posedge clk) begin
		if (ready_run == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_run  <= $urandom_range(16, 200);
		end else begin
			ready_run <= ready_run - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) != 0);
			default: out_ready <= (ready_run[3:0] > 4'd11);
		endcase
	end

	// Result monitor: values are sampled as they stood just before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_reply(status, slot, weight_out, occupancy, total_weight);
	end

	function automatic request_t mk(logic [FUNC_W-1:0] fn, logic [WEIGHT_W-1:0] w,
			logic [CNT_W-1:0] cnt, logic [ID_W-1:0] sid, logic [ID_W-1:0] lidx);
		request_t r;
		r.fn   = fn;
		r.w    = w;
		r.cnt  = cnt;
		r.sid  = sid;
		r.lidx = lidx;
		return r;
	endfunction

	// Weights lean towards the edges of the Q16.16 range.
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 32'h0002_0000);
			default: return $urandom;
		endcase
	endfunction

	// Random item shaped by the current ring state so that pops, reads and
	// updates mostly land inside the held region, with a share of misses.
	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		int unsigned fill;
		fill   = sb.fill;
		pick   = $urandom_range(0, 99);
		r.w    = pick_weight();
		r.cnt  = CNT_W'($urandom);
		r.sid  = ID_W'($urandom);
		r.lidx = ID_W'($urandom);
		if (pick < 30) begin
			r.fn = FN_APPEND;
		end else if (pick < 45) begin
			r.fn = FN_POP;
			case ($urandom_range(0, 9))
				7: r.cnt = CNT_W'(fill);
				8, 9: r.cnt = CNT_W'($urandom_range(fill + 1, 2 ** CNT_W - 1));
				default: r.cnt = CNT_W'($urandom_range(0, (fill < 6) ? fill : 6));
			endcase
		end else if (pick < 65) begin
			r.fn = FN_UPDATE;
			if (fill > 0 && $urandom_range(0, 9) < 6)
				r.sid = ID_W'((sb.head + $urandom_range(0, fill - 1)) % CAP);
		end else if (pick < 80) begin
			r.fn = FN_READ;
			if (fill > 0 && $urandom_range(0, 9) < 7)
				r.lidx = ID_W'($urandom_range(0, fill - 1));
		end else if (pick < 95) begin
			r.fn = FN_MARK;
			if (fill > 0 && $urandom_range(0, 9) < 7)
				r.lidx = ID_W'($urandom_range(0, fill - 1));
		end else if (pick < 97) begin
			r.fn = FN_CLEAR;
		end else begin
			r.fn = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
		end
		return r;
	endfunction

	// Present one item and hold it until taken. Between bursts the sender
	// drops valid for a random gap; a gap of zero gives long unbroken stretches.
	task automatic offer(request_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_valid      <= 1'b1;
		func          <= r.fn;
		weight_in     <= r.w;
		pop_count     <= r.cnt;
		slot_id       <= r.sid;
		logical_index <= r.lidx;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(r);
		burst_left--;
	endtask

	// Sender holds off until every owed result is back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.owed.size() != 0);
		burst_left = 0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: fresh-reset read, field extremes, rejected pops,
		// update of an evicted slot, un-marking, a sum that wraps below zero,
		// the spare codes and a clear.
		offer(mk(FN_READ,    '0,            '0,        '0,        '0));
		offer(mk(FN_APPEND,  '1,            '0,        '0,        '0));
		offer(mk(FN_APPEND,  '0,            '0,        '0,        '0));
		offer(mk(FN_APPEND,  32'h0001_0000, '0,        '0,        '0));
		offer(mk(FN_UPDATE,  32'h8000_0000, '0,        10'd1,     '0));
		// slot outside the held region still feeds the sum
		offer(mk(FN_UPDATE,  '1,            '0,        '1,        '0));
		offer(mk(FN_READ,    '0,            '0,        '0,        '1));
		offer(mk(FN_POP,     '0,            '1,        '0,        '0));
		offer(mk(FN_POP,     '0,            '0,        '0,        '0));
		offer(mk(FN_POP,     '0,            11'd2,     '0,        '0));
		offer(mk(FN_UPDATE,  32'd5,         '0,        '0,        '0));
		// head is now 2: offsets 1023 and 1022 wrap back to slots 1 and 0
		offer(mk(FN_MARK,    '0,            '0,        '0,        '1));
		offer(mk(FN_UPDATE,  '0,            '0,        10'd1,     '0));
		offer(mk(FN_MARK,    '0,            '0,        '0,        10'd1022));
		offer(mk(FN_UPDATE,  '0,            '0,        '0,        '0));
		offer(mk(FN_READ,    '0,            '0,        '0,        10'd5));
		offer(mk(FN_SPARE_A, '1,            '1,        '1,        '1));
		offer(mk(FN_SPARE_B, '1,            '1,        '1,        '1));
		offer(mk(FN_APPEND,  32'hA5A5_5A5A, '1,        '1,        '1));
		offer(mk(FN_CLEAR,   '1,            '1,        '1,        '1));
		offer(mk(FN_READ,    '0,            '0,        '0,        '1));
		offer(mk(FN_POP,     '0,            11'd1,     '0,        '0));
		offer(mk(FN_MARK,    '0,            '0,        '0,        '0));
		drain();

		for (int n = 1; n <= RANDOM_OPS; n++) begin
			offer(random_request());
			if (n % DRAIN_EVERY == 0)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d results: append %0d, pop %0d, update %0d, read %0d, mark %0d,",
			sb.checked, sb.op_seen[FN_APPEND], sb.op_seen[FN_POP], sb.op_seen[FN_UPDATE],
			sb.op_seen[FN_READ], sb.op_seen[FN_MARK]);
		$display("clear %0d, spare %0d; full %0d, pop over %0d, skipped on evicted %0d",
			sb.op_seen[FN_CLEAR], sb.op_seen[FN_SPARE_A] + sb.op_seen[FN_SPARE_B],
			sb.sts_seen[STS_FULL], sb.sts_seen[STS_POP_OVER], sb.sts_seen[STS_EVICTED]);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/wrrb_pkg.sv
rtl/wrrb_ctrl.sv
rtl/wrrb_dpath.sv
rtl/weighted_ring_replay_buffer_core.sv
tb/weighted_ring_replay_buffer_core_tb.sv
